// ----- rtl/hpe_pkg.sv -----
// ---------------------------------------------------------------------------
// hpe_pkg: shared types and constants of the Horner polynomial evaluator
//
// Holds the register map, the reset values of the coefficient registers and
// the configuration bundle that the register file hands to the datapath.
// ---------------------------------------------------------------------------
package hpe_pkg;

	// Default values for the top-level parameters.
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_MAX_DEGREE = 6;

	// Fixed widths of the ports and registers.
	localparam int SAMPLE_WIDTH   = 32;
	localparam int COEF_WIDTH     = 32;
	localparam int NUM_COEFS      = 7;
	localparam int DEG_WIDTH      = 3;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 32;

	typedef logic [DEG_WIDTH-1:0]          degree_t;
	typedef logic signed [COEF_WIDTH-1:0]  coef_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef coef_t [NUM_COEFS-1:0]         coef_arr_t;

	// Register map.
	localparam logic [CFG_IDX_WIDTH-1:0] REG_DEGREE = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF0  = 3'd1;

	// Reset gives the constant polynomial 1.0 in Q16.16.
	localparam coef_t     COEF0_RESET = 32'sd65536;
	localparam coef_arr_t COEFS_RESET =
		coef_arr_t'({{((NUM_COEFS - 1) * COEF_WIDTH){1'b0}}, COEF0_RESET});

	// Configuration as seen by the datapath; degree is already limited.
	typedef struct packed {
		degree_t   degree;
		coef_arr_t coefs;
	} cfg_t;

endpackage

// ----- rtl/hpe_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// hpe_cfg_regs: configuration register file
//
// Holds the degree and the seven coefficients, written through a plain write
// port, and presents the degree limited to the largest supported degree.
// ---------------------------------------------------------------------------
module hpe_cfg_regs #(
	parameter int MAX_DEGREE = hpe_pkg::DEF_MAX_DEGREE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [hpe_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [hpe_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	output hpe_pkg::cfg_t                      cfg
);
	import hpe_pkg::*;

	localparam degree_t DEG_LIMIT = DEG_WIDTH'(MAX_DEGREE);

	degree_t   degree_q;
	coef_arr_t coef_q;

	// Register writes; index zero is the degree, the rest are coefficients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			coef_q   <= COEFS_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_DEGREE) begin
				degree_q <= cfg_data[DEG_WIDTH-1:0];
			end else begin
				coef_q[cfg_index - REG_COEF0] <= coef_t'(cfg_data);
			end
		end
	end

	// A degree above the supported maximum is treated as the maximum.
	always_comb begin
		cfg.degree = (degree_q > DEG_LIMIT) ? DEG_LIMIT : degree_q;
		cfg.coefs  = coef_q;
	end

endmodule

// ----- rtl/hpe_horner_step.sv -----
// ---------------------------------------------------------------------------
// hpe_horner_step: one Horner iteration in three pipeline stages
//
// Stage 1 forms two partial products of acc * x, stage 2 joins them, rounds
// to nearest and saturates, stage 3 adds the coefficient and saturates. When
// the coefficient index is not below the degree the word passes unchanged.
// ---------------------------------------------------------------------------
module hpe_horner_step #(
	parameter int DATA_WIDTH = hpe_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = hpe_pkg::DEF_FRAC_BITS,
	parameter int COEF_IDX   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hpe_pkg::degree_t             degree,
	input  hpe_pkg::coef_t               coef,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  hpe_pkg::sample_t             up_x,
	input  logic signed [DATA_WIDTH-1:0] up_acc,
	input  logic                         up_flag,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output hpe_pkg::sample_t             dn_x,
	output logic signed [DATA_WIDTH-1:0] dn_acc,
	output logic                         dn_flag
);
	import hpe_pkg::*;

	localparam int LW  = DATA_WIDTH / 2;
	localparam int HW  = DATA_WIDTH - LW;
	localparam int PLW = LW + 1 + SAMPLE_WIDTH;
	localparam int PHW = HW + SAMPLE_WIDTH;
	localparam int PW  = DATA_WIDTH + SAMPLE_WIDTH + 1;
	localparam int SW  = ((DATA_WIDTH > COEF_WIDTH) ? DATA_WIDTH : COEF_WIDTH) + 1;

	localparam logic [PW-1:0] ONE_P = PW'(1);
	localparam logic [PW-1:0] HALF  = (ONE_P << FRAC_BITS) >> 1;
	localparam logic signed [DATA_WIDTH-1:0] ACC_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] ACC_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic active;

	// Stage 1 registers.
	logic                         v_s1;
	sample_t                      x_s1;
	logic signed [DATA_WIDTH-1:0] acc_s1;
	logic                         flag_s1;
	logic                         act_s1;
	logic signed [PLW-1:0]        plo_s1;
	logic signed [PHW-1:0]        phi_s1;

	// Stage 2 registers.
	logic                         v_s2;
	sample_t                      x_s2;
	logic signed [DATA_WIDTH-1:0] q_s2;
	logic                         flag_s2;
	logic                         act_s2;

	// Stage 3 registers.
	logic                         v_s3;
	sample_t                      x_s3;
	logic signed [DATA_WIDTH-1:0] acc_s3;
	logic                         flag_s3;

	logic rdy1, rdy2, rdy3;

	logic signed [PLW-1:0]        prod_lo;
	logic signed [PHW-1:0]        prod_hi;
	logic signed [PW-1:0]         p_full;
	logic signed [PW-1:0]         p_rnd;
	logic                         p_fits;
	logic signed [DATA_WIDTH-1:0] p_sat;
	logic signed [SW-1:0]         sum;
	logic                         sum_fits;
	logic signed [DATA_WIDTH-1:0] sum_sat;

	// This step runs only when its coefficient lies below the degree.
	assign active = (degree > DEG_WIDTH'(COEF_IDX));

	// Each stage moves when it is empty or the next stage moves.
	assign rdy3     = !v_s3 || dn_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign up_ready = rdy1;

	// Partial products: unsigned low half and signed high half of acc.
	always_comb begin
		prod_lo = $signed({1'b0, up_acc[LW-1:0]}) * up_x;
		prod_hi = $signed(up_acc[DATA_WIDTH-1:LW]) * up_x;
	end

	// Join, round half up, shift down and saturate to the accumulator width.
	always_comb begin
		p_full = (PW'(phi_s1) <<< LW) + PW'(plo_s1) + $signed(HALF);
		p_rnd  = p_full >>> FRAC_BITS;
		p_fits = (&p_rnd[PW-1:DATA_WIDTH-1]) || !(|p_rnd[PW-1:DATA_WIDTH-1]);
		if (p_fits) begin
			p_sat = p_rnd[DATA_WIDTH-1:0];
		end else begin
			p_sat = p_rnd[PW-1] ? ACC_MIN : ACC_MAX;
		end
	end

	// Add the coefficient and saturate.
	always_comb begin
		sum      = SW'(q_s2) + SW'(coef);
		sum_fits = (&sum[SW-1:DATA_WIDTH-1]) || !(|sum[SW-1:DATA_WIDTH-1]);
		if (sum_fits) begin
			sum_sat = sum[DATA_WIDTH-1:0];
		end else begin
			sum_sat = sum[SW-1] ? ACC_MIN : ACC_MAX;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= up_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1    <= up_x;
			acc_s1  <= up_acc;
			flag_s1 <= up_flag;
			act_s1  <= active;
			plo_s1  <= prod_lo;
			phi_s1  <= prod_hi;
		end
		if (rdy2) begin
			x_s2    <= x_s1;
			q_s2    <= act_s1 ? p_sat : acc_s1;
			flag_s2 <= flag_s1 || (act_s1 && !p_fits);
			act_s2  <= act_s1;
		end
		if (rdy3) begin
			x_s3    <= x_s2;
			acc_s3  <= act_s2 ? sum_sat : q_s2;
			flag_s3 <= flag_s2 || (act_s2 && !sum_fits);
		end
	end

	assign dn_valid = v_s3;
	assign dn_x     = x_s3;
	assign dn_acc   = acc_s3;
	assign dn_flag  = flag_s3;

	// A held last stage keeps its word.
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !dn_ready |=> v_s3 && $stable(acc_s3) && $stable(flag_s3))
		else $error("stalled accumulator word changed");

endmodule

// ----- rtl/horner_polynomial_eval_top.sv -----
// ---------------------------------------------------------------------------
// horner_polynomial_eval_top: pipelined Horner polynomial evaluator
//
// Each input word carries a sample x_value (signed, FRAC_BITS fraction bits).
// The block returns one output word per sample: y_value = p(x) with
// p(x) = coef_0 + coef_1*x + ... + coef_d*x^d, where d is the degree register,
// and saturated = 1 if any product or sum of that evaluation clamped.
// Products round to nearest (ties upward); sums saturate.
// Both channels use valid/stall; a word moves when valid is high and stall
// low. Registers are written through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Index 0 is the degree, indexes 1 to 7 are coef_0 to coef_6.
// The pipeline has one entry stage, three stages per Horner step and one
// output register. The degree does not change the latency; unused steps
// pass words through. Throughput is one sample per cycle when out_stall
// is low. Reset empties the pipeline and loads the constant polynomial 1.0.
// When the receiver stalls, words pile up stage by stage and in_stall rises
// only once the entry stage is full and cannot move.
// ---------------------------------------------------------------------------
module horner_polynomial_eval_top #(
	parameter int DATA_WIDTH = hpe_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = hpe_pkg::DEF_FRAC_BITS,
	parameter int MAX_DEGREE = hpe_pkg::DEF_MAX_DEGREE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [hpe_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [hpe_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  hpe_pkg::sample_t                   x_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output hpe_pkg::sample_t                   y_value,
	output logic                               saturated
);
	import hpe_pkg::*;

	localparam int CW = (DATA_WIDTH > COEF_WIDTH) ? DATA_WIDTH : COEF_WIDTH;
	localparam int OW = (DATA_WIDTH > SAMPLE_WIDTH) ? DATA_WIDTH : SAMPLE_WIDTH;
	localparam logic signed [DATA_WIDTH-1:0] ACC_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] ACC_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam sample_t Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	cfg_t cfg;

	// Entry stage.
	logic                         v_s0;
	sample_t                      x_s0;
	logic signed [DATA_WIDTH-1:0] acc_s0;
	logic                         flag_s0;
	logic                         rdy0;

	// Output register.
	logic    out_valid_q;
	sample_t y_q;
	logic    sat_q;
	logic    rdy_out;

	// Word chain between steps; element 0 is the entry stage.
	logic                         pv   [MAX_DEGREE+1];
	logic                         prdy [MAX_DEGREE+1];
	sample_t                      px   [MAX_DEGREE+1];
	logic signed [DATA_WIDTH-1:0] pacc [MAX_DEGREE+1];
	logic                         pflag[MAX_DEGREE+1];

	logic signed [CW-1:0]         lead_ext;
	logic                         lead_fits;
	logic signed [DATA_WIDTH-1:0] lead_sat;
	logic signed [OW-1:0]         fin_ext;
	logic                         fin_fits;
	sample_t                      fin_sat;

	hpe_cfg_regs #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Leading coefficient, clamped to the accumulator width.
	always_comb begin
		lead_ext  = CW'(cfg.coefs[cfg.degree]);
		lead_fits = (&lead_ext[CW-1:DATA_WIDTH-1]) || !(|lead_ext[CW-1:DATA_WIDTH-1]);
		if (lead_fits) begin
			lead_sat = lead_ext[DATA_WIDTH-1:0];
		end else begin
			lead_sat = lead_ext[CW-1] ? ACC_MIN : ACC_MAX;
		end
	end

	assign rdy0     = !v_s0 || prdy[0];
	assign in_stall = !rdy0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (rdy0) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy0) begin
			x_s0    <= x_value;
			acc_s0  <= lead_sat;
			flag_s0 <= !lead_fits;
		end
	end

	assign pv[0]    = v_s0;
	assign px[0]    = x_s0;
	assign pacc[0]  = acc_s0;
	assign pflag[0] = flag_s0;

	// Horner steps, highest coefficient index first.
	for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
		hpe_horner_step #(
			.DATA_WIDTH(DATA_WIDTH),
			.FRAC_BITS (FRAC_BITS),
			.COEF_IDX  (MAX_DEGREE - 1 - k)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.degree   (cfg.degree),
			.coef     (cfg.coefs[MAX_DEGREE - 1 - k]),
			.up_valid (pv[k]),
			.up_ready (prdy[k]),
			.up_x     (px[k]),
			.up_acc   (pacc[k]),
			.up_flag  (pflag[k]),
			.dn_valid (pv[k+1]),
			.dn_ready (prdy[k+1]),
			.dn_x     (px[k+1]),
			.dn_acc   (pacc[k+1]),
			.dn_flag  (pflag[k+1])
		);
	end

	// Narrow the final accumulator to the output width.
	always_comb begin
		fin_ext  = OW'(pacc[MAX_DEGREE]);
		fin_fits = (&fin_ext[OW-1:SAMPLE_WIDTH-1]) || !(|fin_ext[OW-1:SAMPLE_WIDTH-1]);
		if (fin_fits) begin
			fin_sat = fin_ext[SAMPLE_WIDTH-1:0];
		end else begin
			fin_sat = fin_ext[OW-1] ? Y_MIN : Y_MAX;
		end
	end

	assign rdy_out          = !out_valid_q || !out_stall;
	assign prdy[MAX_DEGREE] = rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= pv[MAX_DEGREE];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			y_q   <= fin_sat;
			sat_q <= pflag[MAX_DEGREE] || !fin_fits;
		end
	end

	assign out_valid = out_valid_q;
	assign y_value   = y_q;
	assign saturated = sat_q;

	// An accepted sample lands in the entry stage.
	a_entry_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s0)
		else $error("accepted sample missing from entry stage");

	// Input backpressure only comes from a full entry stage.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s0 && !prdy[0])
		else $error("input stalled while entry stage could move");

	// A word waiting behind a stalled output stays in the last step.
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pv[MAX_DEGREE] && out_valid && out_stall |=> pv[MAX_DEGREE])
		else $error("word dropped behind stalled output");

endmodule
